// ===== hdl/mmie_pkg.sv =====
// ----------------------------------------------------------------------------
// mmie_pkg - shared types and constants of the mini MIPS executor
// Item layouts of both channels, operation and opcode codes, ALU select.
// ----------------------------------------------------------------------------
package mmie_pkg;

  // Defaults for the top-level parameters
  localparam int DATA_WORDS_DEF = 256;
  localparam int REG_COUNT_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 8;

  // Fixed geometry: 8-bit PC over a 256-word instruction store
  localparam int PC_W        = 8;
  localparam int INSTR_WORDS = 256;
  localparam int INSTR_W     = 16;
  localparam int TGT_W       = 13;

  // Item operations
  localparam logic [1:0] OP_STEP       = 2'd0;
  localparam logic [1:0] OP_LOAD_INSTR = 2'd1;
  localparam logic [1:0] OP_LOAD_DATA  = 2'd2;
  localparam logic [1:0] OP_SET_REG    = 2'd3;

  // Instruction opcodes
  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_J     = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  // R-type function codes; any other code adds
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR
  } alu_sel_t;

  typedef struct packed {
    logic zero;
    logic neg;
    logic ovf;
  } alu_flags_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        index;
    logic [15:0]       instr_word;
    logic signed [7:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        pc_after;
    logic              stopped;
    logic              reg_written;
    logic [2:0]        reg_index;
    logic signed [7:0] result_value;
    logic              mem_written;
    logic [7:0]        mem_address;
    logic              zero_flag;
    logic              negative_flag;
    logic              overflow_flag;
    logic              invalid_opcode;
  } out_item_t;

endpackage

// ===== hdl/mmie_in_if.sv =====
// ----------------------------------------------------------------------------
// mmie_in_if - command channel of the mini MIPS executor
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface mmie_in_if
  import mmie_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mmie_out_if.sv =====
// ----------------------------------------------------------------------------
// mmie_out_if - result channel of the mini MIPS executor
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface mmie_out_if
  import mmie_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mini_mips_instruction_executor_unit.sv =====
// ----------------------------------------------------------------------------
// mini_mips_instruction_executor_unit - small 16-bit-instruction CPU
// Eight registers, 256-word instruction store and data store in synchronous
// RAMs, PC in a register; one command item in, one result item out.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Transfer carries
//  --------+-----+-----------------------------------------------------------
//  cmd     | in  | op, index, instr_word, data_value
//  rsp     | out | pc_after, stopped, register/memory write info, flags
//
// Sequence: a load item (ops 1 to 3) goes from idle to hand-off; a step runs
// instruction read, register read, execute, hand-off, and LW adds a data
// store read before hand-off. The registered RAM reads set these steps.
// Reset: a clearing pass over all 256 instruction words zeroes all three
// stores; cmd is not ready until it ends.
// Stalls: a finished result waits in its own register while rsp holds the
// previous one, and cmd stays not ready until that result moves into the
// output register, so at most one item sits behind a stalled rsp.
// ----------------------------------------------------------------------------
module mini_mips_instruction_executor_unit
  import mmie_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mmie_in_if.sink    cmd,
  mmie_out_if.source rsp
);

  localparam int DATA_AW  = $clog2(DATA_WORDS);
  localparam int REG_W    = $clog2(REG_COUNT);
  localparam int INSTR_AW = $clog2(INSTR_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_EXE,
    S_MEM,
    S_DONE
  } state_t;

  state_t                 state;
  logic [INSTR_AW-1:0]    clr_idx;
  logic [PC_W-1:0]        pc;
  logic [INSTR_W-1:0]     ins;
  out_item_t              res;
  out_item_t              rsp_data;
  logic                   rsp_valid;

  logic                   cmd_xfer;
  logic                   out_free;
  out_item_t              load_res;

  // RAM ports
  logic                   instr_we;
  logic [INSTR_AW-1:0]    instr_waddr;
  logic [INSTR_W-1:0]     instr_wdata;
  logic [INSTR_W-1:0]     instr_rdata;
  logic                   data_we;
  logic [DATA_AW-1:0]     data_waddr;
  logic [DATA_WIDTH-1:0]  data_wdata;
  logic [DATA_AW-1:0]     data_raddr;
  logic [DATA_WIDTH-1:0]  data_rdata;
  logic                   reg_we;
  logic [REG_W-1:0]       reg_waddr;
  logic [DATA_WIDTH-1:0]  reg_wdata;
  logic [DATA_WIDTH-1:0]  rs_val;
  logic [DATA_WIDTH-1:0]  rt_val;

  // Execute-stage decode
  logic [3:0]             opc;
  logic [2:0]             rs_f;
  logic [2:0]             rt_f;
  logic [2:0]             rd_f;
  logic [2:0]             fn_f;
  logic [DATA_WIDTH-1:0]  imm_w;
  alu_sel_t               alu_sel;
  logic [DATA_WIDTH-1:0]  alu_b;
  logic [DATA_WIDTH-1:0]  alu_value;
  alu_flags_t             alu_flags;
  logic [TGT_W-1:0]       tgt;
  logic [PC_W-1:0]        pc_next;
  logic                   stop_next;

  // Index wrap modulo DATA_WORDS, worked out at elaboration
  logic [DATA_AW-1:0]     wrap_tbl [INSTR_WORDS];

  for (genvar g = 0; g < INSTR_WORDS; g++) begin : g_wrap
    assign wrap_tbl[g] = DATA_AW'(g % DATA_WORDS);
  end

  assign cmd.ready = (state == S_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Output slot is free now or frees at this edge
  assign out_free  = !rsp_valid || rsp.ready;

  // Fields of the held instruction
  assign opc   = ins[15:12];
  assign rs_f  = ins[11:9];
  assign rt_f  = ins[8:6];
  assign rd_f  = ins[5:3];
  assign fn_f  = ins[2:0];
  assign imm_w = DATA_WIDTH'($signed(ins[5:0]));

  // --------------------------------------------------------------------------
  // Stores: instruction store, data store, and the register file as two
  // banks written together so that rs and rt read in the same cycle.
  // --------------------------------------------------------------------------
  mmie_ram #(.WIDTH(INSTR_W), .DEPTH(INSTR_WORDS)) u_instr_ram (
    .clk   (clk),
    .we    (instr_we),
    .waddr (instr_waddr),
    .wdata (instr_wdata),
    .raddr (pc),
    .rdata (instr_rdata)
  );

  mmie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DATA_WORDS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  mmie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rs_bank (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (REG_W'(instr_rdata[11:9])),
    .rdata (rs_val)
  );

  mmie_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rt_bank (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (REG_W'(instr_rdata[8:6])),
    .rdata (rt_val)
  );

  // --------------------------------------------------------------------------
  // ALU: R type and BEQ use rt, the rest add the sign-extended immediate
  // --------------------------------------------------------------------------
  always_comb begin
    alu_b   = imm_w;
    alu_sel = ALU_ADD;
    unique case (opc)
      OPC_RTYPE: begin
        alu_b = rt_val;
        case (fn_f)
          FN_SUB:  alu_sel = ALU_SUB;
          FN_AND:  alu_sel = ALU_AND;
          FN_OR:   alu_sel = ALU_OR;
          default: alu_sel = ALU_ADD;
        endcase
      end
      OPC_BEQ: begin
        alu_b   = rt_val;
        alu_sel = ALU_SUB;
      end
      default: ;
    endcase
  end

  mmie_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .sel   (alu_sel),
    .a     (rs_val),
    .b     (alu_b),
    .value (alu_value),
    .flags (alu_flags)
  );

  // Data address: low byte of the sum, wrapped onto the data store
  assign data_raddr = wrap_tbl[alu_value[7:0]];

  // --------------------------------------------------------------------------
  // Next PC: signed target wide enough for a jump, then clamp and saturate
  // --------------------------------------------------------------------------
  always_comb begin
    tgt = TGT_W'(pc) + TGT_W'(1);
    if (opc == OPC_BEQ && alu_flags.zero) begin
      tgt = tgt + TGT_W'($signed(ins[5:0]));
    end else if (opc == OPC_J) begin
      tgt = TGT_W'(ins[11:0]);
    end
    stop_next = 1'b0;
    if (tgt[TGT_W-1]) begin
      pc_next = '0;
    end else if (|tgt[TGT_W-2:PC_W]) begin
      pc_next   = '1;
      stop_next = 1'b1;
    end else begin
      pc_next = tgt[PC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Result of a command taken in idle; a step fills in the rest later
  // --------------------------------------------------------------------------
  always_comb begin
    load_res          = '0;
    load_res.pc_after = pc;
    case (cmd.data.op)
      OP_LOAD_DATA: begin
        load_res.result_value = cmd.data.data_value;
        load_res.mem_written  = 1'b1;
        load_res.mem_address  = cmd.data.index;
      end
      OP_SET_REG: begin
        load_res.reg_written  = 1'b1;
        load_res.reg_index    = cmd.data.index[2:0];
        load_res.result_value = cmd.data.data_value;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Store write ports: clearing pass, load items, execute and LW write-back
  // --------------------------------------------------------------------------
  always_comb begin
    instr_we    = 1'b0;
    instr_waddr = cmd.data.index;
    instr_wdata = cmd.data.instr_word;
    data_we     = 1'b0;
    data_waddr  = wrap_tbl[cmd.data.index];
    data_wdata  = DATA_WIDTH'($signed(cmd.data.data_value));
    reg_we      = 1'b0;
    reg_waddr   = REG_W'(cmd.data.index[2:0]);
    reg_wdata   = DATA_WIDTH'($signed(cmd.data.data_value));
    unique case (state)
      S_CLEAR: begin
        // Zero one word of each store a cycle
        instr_we    = 1'b1;
        instr_waddr = clr_idx;
        instr_wdata = '0;
        data_we     = ({1'b0, clr_idx} < (INSTR_AW + 1)'(DATA_WORDS));
        data_waddr  = clr_idx[DATA_AW-1:0];
        data_wdata  = '0;
        reg_we      = ({1'b0, clr_idx} < (INSTR_AW + 1)'(REG_COUNT));
        reg_waddr   = clr_idx[REG_W-1:0];
        reg_wdata   = '0;
      end
      S_IDLE: begin
        if (cmd_xfer) begin
          case (cmd.data.op)
            OP_LOAD_INSTR: instr_we = 1'b1;
            OP_LOAD_DATA:  data_we  = 1'b1;
            OP_SET_REG:    reg_we   = 1'b1;
            default: ;
          endcase
        end
      end
      S_EXE: begin
        unique case (opc)
          OPC_RTYPE: begin
            reg_we    = 1'b1;
            reg_waddr = REG_W'(rd_f);
            reg_wdata = alu_value;
          end
          OPC_ADDI: begin
            reg_we    = 1'b1;
            reg_waddr = REG_W'(rt_f);
            reg_wdata = alu_value;
          end
          OPC_SW: begin
            data_we    = 1'b1;
            data_waddr = data_raddr;
            data_wdata = rt_val;
          end
          default: ;
        endcase
      end
      S_MEM: begin
        // LW write-back of the word read in execute
        reg_we    = 1'b1;
        reg_waddr = REG_W'(rt_f);
        reg_wdata = data_rdata;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, PC, pending result and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pc        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Advance a finished result into the output; drop the output once taken
      if (state == S_DONE && out_free) begin
        rsp_data  <= res;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + INSTR_AW'(1);
          if (&clr_idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_xfer) begin
            res   <= load_res;
            state <= (cmd.data.op == OP_STEP) ? S_DEC : S_DONE;
          end
        end
        S_DEC: begin
          // Hold the fetched word; the register banks read rs and rt now
          ins   <= instr_rdata;
          state <= S_EXE;
        end
        S_EXE: begin
          pc           <= pc_next;
          res.pc_after <= pc_next;
          res.stopped  <= stop_next;
          state        <= (opc == OPC_LW) ? S_MEM : S_DONE;
          unique case (opc)
            OPC_RTYPE, OPC_ADDI: begin
              res.reg_written   <= 1'b1;
              res.reg_index     <= (opc == OPC_RTYPE) ? rd_f : rt_f;
              res.result_value  <= alu_value[7:0];
              res.zero_flag     <= alu_flags.zero;
              res.negative_flag <= alu_flags.neg;
              res.overflow_flag <= alu_flags.ovf;
            end
            OPC_LW: begin
              res.reg_written   <= 1'b1;
              res.reg_index     <= rt_f;
              res.mem_address   <= alu_value[7:0];
              res.zero_flag     <= alu_flags.zero;
              res.negative_flag <= alu_flags.neg;
              res.overflow_flag <= alu_flags.ovf;
            end
            OPC_SW: begin
              res.result_value  <= rt_val[7:0];
              res.mem_written   <= 1'b1;
              res.mem_address   <= alu_value[7:0];
              res.zero_flag     <= alu_flags.zero;
              res.negative_flag <= alu_flags.neg;
              res.overflow_flag <= alu_flags.ovf;
            end
            OPC_BEQ: begin
              res.result_value  <= alu_value[7:0];
              res.zero_flag     <= alu_flags.zero;
              res.negative_flag <= alu_flags.neg;
              res.overflow_flag <= alu_flags.ovf;
            end
            OPC_J: ;
            default: res.invalid_opcode <= 1'b1;
          endcase
        end
        S_MEM: begin
          res.result_value <= data_rdata[7:0];
          state            <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output slot is free or freeing
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_clear_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.ready)
    else $error("command taken during clearing pass");

  a_load_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && cmd.data.op != OP_STEP) |=> ($stable(pc) && state == S_DONE))
    else $error("load item moved the PC or skipped hand-off");

  a_stop_saturates: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.stopped) |-> (rsp.data.pc_after == '1))
    else $error("stopped result without saturated PC");

  a_one_write_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.reg_written && rsp.data.mem_written))
    else $error("result reports register and memory write together");

endmodule

// ===== hdl/mmie_ram.sv =====
// ----------------------------------------------------------------------------
// mmie_ram - generic single-port-write RAM with registered read
// One write and one read per cycle; read data appears in the next cycle.
// ----------------------------------------------------------------------------
module mmie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mmie_alu.sv =====
// ----------------------------------------------------------------------------
// mmie_alu - wrapping ALU of the mini MIPS executor
// Add, subtract, and, or on DATA_WIDTH bits with zero, negative, overflow.
// ----------------------------------------------------------------------------
module mmie_alu
  import mmie_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  alu_sel_t              sel,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic [DATA_WIDTH-1:0] value,
  output alu_flags_t            flags
);

  always_comb begin
    flags.ovf = 1'b0;
    unique case (sel)
      ALU_SUB: begin
        value     = a - b;
        flags.ovf = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) &
                    (value[DATA_WIDTH-1] ^ a[DATA_WIDTH-1]);
      end
      ALU_AND: value = a & b;
      ALU_OR:  value = a | b;
      default: begin
        value     = a + b;
        flags.ovf = ~(a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) &
                    (value[DATA_WIDTH-1] ^ a[DATA_WIDTH-1]);
      end
    endcase
    flags.zero = (value == '0);
    flags.neg  = value[DATA_WIDTH-1];
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the mini MIPS instruction executor
// Drives command transfers and checks every result transfer, field by
// field, against typed results or an in-bench copy of CPU state and ISA.
// A short directed program runs first, then randomised programs and loads.
// ----------------------------------------------------------------------------
module tb_top;
  import mmie_pkg::*;

  // Opcode that decodes to nothing; only the PC moves
  localparam logic [3:0] OPC_UNUSED = 4'd1;

  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] value;
    alu_flags_t flags;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmie_in_if  cmd_if ();
  mmie_out_if rsp_if ();

  mini_mips_instruction_executor_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Architectural copy of the CPU, advanced once per accepted command
  // --------------------------------------------------------------------------
  logic [7:0]  arch_regs  [8];
  logic [15:0] prog_words [256];
  logic [7:0]  data_words [256];
  int          arch_pc;

  out_item_t pending_results [$];
  int        mismatch_count = 0;

  // Set during the long stretch in which neither side idles
  bit calm = 1'b0;

  function automatic alu_res_t alu_calc(alu_sel_t sel, logic [7:0] a, logic [7:0] b);
    alu_res_t r;
    r.flags = '0;
    case (sel)
      ALU_SUB: begin
        r.value     = a - b;
        r.flags.ovf = (a[7] ^ b[7]) & (r.value[7] ^ a[7]);
      end
      ALU_AND: r.value = a & b;
      ALU_OR:  r.value = a | b;
      default: begin
        r.value     = a + b;
        r.flags.ovf = ~(a[7] ^ b[7]) & (r.value[7] ^ a[7]);
      end
    endcase
    r.flags.zero = (r.value == 8'd0);
    r.flags.neg  = r.value[7];
    return r;
  endfunction

  // Apply one command to the architectural copy and return its result
  function automatic out_item_t execute_item(in_item_t it);
    out_item_t  r;
    logic [15:0] ins;
    logic [2:0] rs, rt, rd;
    logic [7:0] imm8;
    int         imm_int;
    int         nxt;
    bit         flagged;
    alu_sel_t   sel;
    alu_res_t   res;
    r   = '0;
    res = '0;
    case (it.op)
      OP_LOAD_INSTR: prog_words[it.index] = it.instr_word;
      OP_LOAD_DATA: begin
        data_words[it.index] = it.data_value;
        r.result_value = it.data_value;
        r.mem_written  = 1'b1;
        r.mem_address  = it.index;
      end
      OP_SET_REG: begin
        arch_regs[it.index[2:0]] = it.data_value;
        r.reg_written  = 1'b1;
        r.reg_index    = it.index[2:0];
        r.result_value = it.data_value;
      end
      default: begin
        ins     = prog_words[arch_pc[7:0]];
        rs      = ins[11:9];
        rt      = ins[8:6];
        rd      = ins[5:3];
        imm8    = {{2{ins[5]}}, ins[5:0]};
        imm_int = ins[5] ? int'(ins[5:0]) - 64 : int'(ins[5:0]);
        nxt     = arch_pc + 1;
        flagged = 1'b1;
        case (ins[15:12])
          OPC_RTYPE: begin
            // Unlisted function codes fall back to an add
            case (ins[2:0])
              FN_SUB:  sel = ALU_SUB;
              FN_AND:  sel = ALU_AND;
              FN_OR:   sel = ALU_OR;
              default: sel = ALU_ADD;
            endcase
            res = alu_calc(sel, arch_regs[rs], arch_regs[rt]);
            arch_regs[rd]  = res.value;
            r.reg_written  = 1'b1;
            r.reg_index    = rd;
            r.result_value = res.value;
          end
          OPC_ADDI: begin
            res = alu_calc(ALU_ADD, arch_regs[rs], imm8);
            arch_regs[rt]  = res.value;
            r.reg_written  = 1'b1;
            r.reg_index    = rt;
            r.result_value = res.value;
          end
          OPC_LW, OPC_SW: begin
            // Flags come from the address add, which wraps to 8 bits
            res = alu_calc(ALU_ADD, arch_regs[rs], imm8);
            r.mem_address = res.value;
            if (ins[15:12] == OPC_LW) begin
              arch_regs[rt] = data_words[res.value];
              r.reg_written = 1'b1;
              r.reg_index   = rt;
            end else begin
              data_words[res.value] = arch_regs[rt];
              r.mem_written = 1'b1;
            end
            r.result_value = arch_regs[rt];
          end
          OPC_BEQ: begin
            res = alu_calc(ALU_SUB, arch_regs[rs], arch_regs[rt]);
            r.result_value = res.value;
            if (res.flags.zero) nxt = arch_pc + 1 + imm_int;
          end
          OPC_J: begin
            flagged = 1'b0;
            nxt     = int'(ins[11:0]);
          end
          default: begin
            flagged          = 1'b0;
            r.invalid_opcode = 1'b1;
          end
        endcase
        if (flagged) begin
          r.zero_flag     = res.flags.zero;
          r.negative_flag = res.flags.neg;
          r.overflow_flag = res.flags.ovf;
        end
        // Saturate past the top of the store; clamp a backward branch at zero
        if (nxt > 255) begin
          nxt       = 255;
          r.stopped = 1'b1;
        end
        if (nxt < 0) nxt = 0;
        arch_pc = nxt;
      end
    endcase
    r.pc_after = arch_pc[7:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Builders for commands, instruction words and quiet results
  // --------------------------------------------------------------------------
  function automatic in_item_t cmd_item(logic [1:0] op, logic [7:0] index,
                                        logic [15:0] word, logic [7:0] value);
    in_item_t it;
    it.op         = op;
    it.index      = index;
    it.instr_word = word;
    it.data_value = value;
    return it;
  endfunction

  function automatic logic [15:0] enc_rtype(logic [2:0] rs, logic [2:0] rt,
                                            logic [2:0] rd, logic [2:0] fn);
    return {OPC_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] enc_itype(logic [3:0] opc, logic [2:0] rs,
                                            logic [2:0] rt, logic [5:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [15:0] enc_jump(logic [11:0] addr);
    return {OPC_J, addr};
  endfunction

  // A result with every field idle but the PC
  function automatic out_item_t quiet_result(logic [7:0] pc);
    out_item_t r;
    r          = '0;
    r.pc_after = pc;
    return r;
  endfunction

  // Random instruction word, mostly well-formed so programs run deep
  function automatic logic [15:0] random_instr();
    logic [3:0]  opc;
    logic [11:0] target;
    case ($urandom_range(0, 9))
      0, 1, 2: return enc_rtype(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
      3: return enc_itype(OPC_ADDI, 3'($urandom), 3'($urandom), 6'($urandom));
      4: return enc_itype(OPC_LW, 3'($urandom), 3'($urandom), 6'($urandom));
      5: return enc_itype(OPC_SW, 3'($urandom), 3'($urandom), 6'($urandom));
      6: return enc_itype(OPC_BEQ, 3'($urandom), 3'($urandom), 6'($urandom));
      7: begin
        // Keep most jumps inside the store; a few run off the top
        target = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 255));
        return enc_jump(target);
      end
      8: begin
        do opc = 4'($urandom);
        while (opc inside {OPC_RTYPE, OPC_J, OPC_ADDI, OPC_BEQ, OPC_LW, OPC_SW});
        return {opc, 12'($urandom)};
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command side: idle at random, hold until the transfer, then log the
  // expected result (the typed one for table rows that carry it)
  // --------------------------------------------------------------------------
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    while (!calm && $urandom_range(0, 99) < 17) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = execute_item(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, field-by-field comparison
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= 17);
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : rsp_check
    out_item_t got;
    out_item_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, pc_after 0x%0h",
                                  got.pc_after));
      end else begin
        want = pending_results.pop_front();
        check_field("pc_after",       16'(got.pc_after),       16'(want.pc_after));
        check_field("stopped",        16'(got.stopped),        16'(want.stopped));
        check_field("reg_written",    16'(got.reg_written),    16'(want.reg_written));
        check_field("reg_index",      16'(got.reg_index),      16'(want.reg_index));
        check_field("result_value",   16'(got.result_value),   16'(want.result_value));
        check_field("mem_written",    16'(got.mem_written),    16'(want.mem_written));
        check_field("mem_address",    16'(got.mem_address),    16'(want.mem_address));
        check_field("zero_flag",      16'(got.zero_flag),      16'(want.zero_flag));
        check_field("negative_flag",  16'(got.negative_flag),  16'(want.negative_flag));
        check_field("overflow_flag",  16'(got.overflow_flag),  16'(want.overflow_flag));
        check_field("invalid_opcode", 16'(got.invalid_opcode), 16'(want.invalid_opcode));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  in_item_t  dir_stim  [$];
  bit        dir_typed [$];
  out_item_t dir_want  [$];

  task automatic add_row(in_item_t it, bit typed, out_item_t want);
    dir_stim.push_back(it);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  initial begin
    out_item_t w;
    out_item_t none;
    int        kind;
    logic [7:0] idx;
    none = '0;

    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rsp_if.ready = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (prog_words[i]) prog_words[i] = '0;
    foreach (data_words[i]) data_words[i] = '0;
    arch_pc = 0;

    // Directed program. Typed rows carry results that follow at a glance;
    // every other row is checked against the architectural copy.

    // Step straight after reset: the all-zero word is ADD r0, r0, r0
    w = quiet_result(8'd1);
    w.reg_written = 1'b1;
    w.zero_flag   = 1'b1;
    add_row(cmd_item(OP_STEP, 8'd0, 16'h0000, 8'h00), 1'b1, w);

    // Register loads at the value extremes; only the low index bits count
    w = quiet_result(8'd1);
    w.reg_written  = 1'b1;
    w.reg_index    = 3'd1;
    w.result_value = 8'h7F;
    add_row(cmd_item(OP_SET_REG, 8'h01, 16'hFFFF, 8'h7F), 1'b1, w);
    w.reg_index    = 3'd2;
    w.result_value = 8'h80;
    add_row(cmd_item(OP_SET_REG, 8'hFA, 16'h0000, 8'h80), 1'b1, w);
    w.reg_index    = 3'd3;
    w.result_value = 8'h01;
    add_row(cmd_item(OP_SET_REG, 8'h0B, 16'h5A5A, 8'h01), 1'b1, w);

    // Data load at the top address
    w = quiet_result(8'd1);
    w.mem_written  = 1'b1;
    w.mem_address  = 8'hFF;
    w.result_value = 8'hFF;
    add_row(cmd_item(OP_LOAD_DATA, 8'hFF, 16'hA5A5, 8'hFF), 1'b1, w);

    // Program: signed overflow on add (unlisted funct) and sub, AND to zero,
    // OR to all ones, a load and a store whose addresses wrap, a branch not
    // taken, a taken branch landing below zero, a jump past the top, and an
    // unknown opcode at the last word
    w = quiet_result(8'd1);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd1, enc_rtype(3'd1, 3'd3, 3'd4, 3'd7), 8'h00), 1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd2, enc_rtype(3'd2, 3'd3, 3'd5, FN_SUB), 8'h00), 1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd3, enc_rtype(3'd1, 3'd2, 3'd6, FN_AND), 8'h00), 1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd4, enc_rtype(3'd1, 3'd2, 3'd7, FN_OR), 8'h00), 1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd5, enc_itype(OPC_LW, 3'd2, 3'd4, 6'h3F), 8'h00),
            1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd6, enc_itype(OPC_SW, 3'd7, 3'd7, 6'h3F), 8'h00),
            1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd7, enc_itype(OPC_BEQ, 3'd1, 3'd2, 6'd5), 8'h00),
            1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd8, enc_itype(OPC_BEQ, 3'd0, 3'd0, 6'h20), 8'h00),
            1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'd0, enc_jump(12'hFFF), 8'h00), 1'b1, w);
    add_row(cmd_item(OP_LOAD_INSTR, 8'hFF, {OPC_UNUSED, 12'h234}, 8'h00), 1'b1, w);

    for (int s = 1; s <= 8; s++)
      add_row(cmd_item(OP_STEP, 8'($urandom), 16'($urandom), 8'($urandom)), 1'b0, none);

    // Jump off the top saturates; the unknown word at the top then stays put
    w = quiet_result(8'hFF);
    w.stopped = 1'b1;
    add_row(cmd_item(OP_STEP, 8'h00, 16'h0000, 8'h00), 1'b1, w);
    w.invalid_opcode = 1'b1;
    add_row(cmd_item(OP_STEP, 8'hFF, 16'hFFFF, 8'h7F), 1'b1, w);

    // Release reset on a clock edge, then walk the table
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_stim[i]) send_item(dir_stim[i], dir_typed[i], dir_want[i]);

    // Random part: mostly steps over programs written near the PC, with
    // loose loads and register writes mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        send_item(cmd_item(OP_STEP, 8'($urandom), 16'($urandom), 8'($urandom)), 1'b0, none);
      end else if (kind < 75) begin
        idx = ($urandom_range(0, 9) < 7) ? 8'(arch_pc + $urandom_range(0, 3))
                                         : 8'($urandom);
        send_item(cmd_item(OP_LOAD_INSTR, idx, random_instr(), 8'($urandom)), 1'b0, none);
      end else if (kind < 85) begin
        send_item(cmd_item(OP_LOAD_DATA, 8'($urandom), 16'($urandom), 8'($urandom)),
                  1'b0, none);
      end else begin
        send_item(cmd_item(OP_SET_REG, 8'($urandom), 16'($urandom), 8'($urandom)),
                  1'b0, none);
      end
    end
    calm = 1'b0;
    cmd_if.valid <= 1'b0;

    // Drain: wait out every outstanding result, then a little longer to
    // catch anything spurious
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mmie_pkg.sv
hdl/mmie_in_if.sv
hdl/mmie_out_if.sv
hdl/mmie_ram.sv
hdl/mmie_alu.sv
hdl/mini_mips_instruction_executor_unit.sv
dv/tb_top.sv
